>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the window tracker RTL
// Each macro places one labeled concurrent check on clk, disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define SBWT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("window tracker check failed");

// Check cons in the cycle after ante.
`define SBWT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("window tracker check failed");

`endif

>>> rtl/sbwt_pkg.sv
// ----------------------------------------------------------------------------
// sbwt_pkg
// Operation codes, queue sizing and the command and status types passed
// between the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbwt_pkg;

  // Input operation codes
  localparam logic [1:0] OP_MOVE    = 2'd0;
  localparam logic [1:0] OP_SUSPEND = 2'd1;
  localparam logic [1:0] OP_UPDATE  = 2'd2;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One update as classified by the front end
  typedef struct packed {
    logic               moved;    // unsuspended or moved with a position held
    logic               full;     // full recount of the window
    logic               refresh;  // margin test, shift only on a breach
    logic               focus;    // announce new focus
    logic signed [15:0] cam_x;
    logic signed [15:0] cam_y;
    logic signed [13:0] blk_x;    // window origin block for the camera
    logic signed [13:0] blk_y;
  } cmd_t;

  // Queue occupancy seen by both sides
  typedef struct packed {
    logic full;
    logic avail;
  } queue_status_t;

endpackage

`default_nettype wire

>>> rtl/sbwt_queue.sv
// ----------------------------------------------------------------------------
// sbwt_queue
// Short command FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sbwt_queue
  import sbwt_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire cmd_t          wr_cmd,
  input  wire logic          pop,
  output cmd_t               rd_cmd,
  output queue_status_t      stat
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  // Status and head entry
  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.avail = (count != '0);
  assign rd_cmd     = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  `SBWT_ASSERT_NOW(q_no_overflow, push, !stat.full)
  `SBWT_ASSERT_NOW(q_no_underflow, pop, stat.avail)

endmodule

`default_nettype wire

>>> rtl/sbwt_front.sv
// ----------------------------------------------------------------------------
// sbwt_front
// Accepts input beats, tracks camera position and pending flags, and turns
// each update into a command for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbwt_front
  import sbwt_pkg::*;
#(
  parameter int BLOCK_TILES = 8,
  parameter int VIEW_TILES  = 15,
  parameter int PAD_TILES   = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         operation,
  input  wire logic signed [15:0] tile_x,
  input  wire logic signed [15:0] tile_y,
  input  wire queue_status_t      q_stat,
  output logic                    push,
  output cmd_t                    cmd
);

  localparam int MARGIN = PAD_TILES + VIEW_TILES / 2;
  // Exact reciprocal for a 16-bit dividend and divisors from 2 up to 64
  localparam int DIV_SHIFT = 22;
  localparam int RECIP_W   = DIV_SHIFT;
  localparam int PROD_W    = 16 + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(BLOCK_TILES) - 64'd1) / 64'(BLOCK_TILES));
  localparam logic signed [16:0] MARGIN_C = 17'(MARGIN);

  logic signed [15:0] cam_x;
  logic signed [15:0] cam_y;
  logic               has_position;
  logic               suspended;
  logic               pending_unsuspend;
  logic               pending_move;
  logic               pending_focus;
  // Magnitude and sign of camera tile minus margin, for the block divide
  logic [15:0]        tmag_x;
  logic [15:0]        tmag_y;
  logic               tneg_x;
  logic               tneg_y;

  logic               accept;
  logic               same_pos;
  logic signed [16:0] t_x;
  logic signed [16:0] t_y;
  logic [PROD_W-1:0]  prod_x;
  logic [PROD_W-1:0]  prod_y;
  logic [15:0]        qm_x;
  logic [15:0]        qm_y;
  logic               moved;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign same_pos = has_position && (tile_x == cam_x) && (tile_y == cam_y);
  assign push     = accept && (operation == OP_UPDATE);

  // Offset the incoming tile by the margin
  assign t_x = 17'(tile_x) - MARGIN_C;
  assign t_y = 17'(tile_y) - MARGIN_C;

  // Divide magnitudes by the block size; negative side rounds one further down
  assign prod_x = PROD_W'(tmag_x) * PROD_W'(RECIP);
  assign prod_y = PROD_W'(tmag_y) * PROD_W'(RECIP);
  assign qm_x   = prod_x[DIV_SHIFT +: 16];
  assign qm_y   = prod_y[DIV_SHIFT +: 16];

  // Classify the update
  assign moved       = (pending_unsuspend || pending_move) && has_position;
  assign cmd.moved   = moved;
  assign cmd.full    = moved && pending_unsuspend;
  assign cmd.refresh = moved && !pending_unsuspend && !suspended;
  assign cmd.focus   = pending_focus;
  assign cmd.cam_x   = cam_x;
  assign cmd.cam_y   = cam_y;
  assign cmd.blk_x   = tneg_x ? signed'(~qm_x[13:0]) : signed'(qm_x[13:0]);
  assign cmd.blk_y   = tneg_y ? signed'(~qm_y[13:0]) : signed'(qm_y[13:0]);

  // Update camera state and pending flags
  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x             <= '0;
      cam_y             <= '0;
      has_position      <= 1'b0;
      suspended         <= 1'b1;
      pending_unsuspend <= 1'b0;
      pending_move      <= 1'b0;
      pending_focus     <= 1'b0;
    end else if (accept) begin
      unique case (operation)
        OP_MOVE: begin
          if (!same_pos) begin
            if (suspended && !pending_unsuspend) begin
              suspended         <= 1'b0;
              pending_unsuspend <= 1'b1;
              pending_focus     <= 1'b1;
            end else begin
              pending_move <= 1'b1;
            end
            cam_x        <= tile_x;
            cam_y        <= tile_y;
            has_position <= 1'b1;
          end
        end
        OP_SUSPEND: begin
          has_position <= 1'b0;
          suspended    <= 1'b1;
        end
        OP_UPDATE: begin
          pending_unsuspend <= 1'b0;
          pending_move      <= 1'b0;
          pending_focus     <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Hold divide operands for the recorded position
  always_ff @(posedge clk) begin
    if (accept && (operation == OP_MOVE) && !same_pos) begin
      tneg_x <= t_x[16];
      tneg_y <= t_y[16];
      tmag_x <= t_x[16] ? 16'(-t_x) : t_x[15:0];
      tmag_y <= t_y[16] ? 16'(-t_y) : t_y[15:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/sbwt_back.sv
// ----------------------------------------------------------------------------
// sbwt_back
// Executes update commands: margin test, window origin, sync map shift,
// and the registered result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sbwt_back
  import sbwt_pkg::*;
#(
  parameter int BLOCK_TILES   = 8,
  parameter int VIEW_TILES    = 15,
  parameter int PAD_TILES     = 2,
  parameter int WINDOW_BLOCKS = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire queue_status_t      q_stat,
  input  wire cmd_t               cmd,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    camera_moved,
  output logic signed [15:0]      camera_x,
  output logic signed [15:0]      camera_y,
  output logic                    window_shifted,
  output logic signed [13:0]      origin_block_x,
  output logic signed [13:0]      origin_block_y,
  output logic [15:0]             fresh_cells,
  output logic                    focus_changed
);

  localparam int CELLS  = WINDOW_BLOCKS * WINDOW_BLOCKS;
  localparam int CELL_W = $clog2(CELLS);
  localparam int MARGIN = PAD_TILES + VIEW_TILES / 2;
  localparam int FX_W   = 14 + $clog2(BLOCK_TILES) + 1;
  localparam int CMP_W  = FX_W + 2;
  localparam logic signed [CMP_W-1:0] BT_C     = CMP_W'(BLOCK_TILES);
  localparam logic signed [CMP_W-1:0] SPAN_C   = CMP_W'(WINDOW_BLOCKS * BLOCK_TILES);
  localparam logic signed [CMP_W-1:0] MARGIN_C = CMP_W'(MARGIN);
  localparam logic signed [15:0]      WB_C     = 16'(WINDOW_BLOCKS);
  localparam logic [CELLS-1:0]        ALL_CELLS = '1;

  logic signed [13:0]      origin_bx;
  logic signed [13:0]      origin_by;
  logic [CELLS-1:0]        sync_map;

  logic signed [CMP_W-1:0] fx;
  logic signed [CMP_W-1:0] fy;
  logic signed [CMP_W-1:0] d_left;
  logic signed [CMP_W-1:0] d_top;
  logic signed [CMP_W-1:0] d_right;
  logic signed [CMP_W-1:0] d_bottom;
  logic                    breach;
  logic                    recount;
  logic signed [14:0]      dx;
  logic signed [14:0]      dy;
  logic [CELLS-1:0]        saved;
  logic [CELLS-1:0]        sync_work;
  logic [15:0]             fresh_bits;
  logic                    has_result;
  logic                    out_free;

  // Margin test against the current window edges
  always_comb begin
    fx       = CMP_W'(origin_bx) * BT_C;
    fy       = CMP_W'(origin_by) * BT_C;
    d_left   = CMP_W'(cmd.cam_x) - fx;
    d_top    = CMP_W'(cmd.cam_y) - fy;
    d_right  = fx + SPAN_C - CMP_W'(cmd.cam_x);
    d_bottom = fy + SPAN_C - CMP_W'(cmd.cam_y);
    breach   = (d_left < MARGIN_C) || (d_top < MARGIN_C) ||
               (d_right < MARGIN_C) || (d_bottom < MARGIN_C);
  end

  assign recount = cmd.full || (cmd.refresh && breach);
  assign dx      = 15'(cmd.blk_x) - 15'(origin_bx);
  assign dy      = 15'(cmd.blk_y) - 15'(origin_by);

  // Shift the sync map: each target cell pulls from its source cell
  always_comb begin
    saved = '0;
    for (int ty = 0; ty < WINDOW_BLOCKS; ty++) begin
      for (int tx = 0; tx < WINDOW_BLOCKS; tx++) begin
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic               in_rng;
        logic [CELL_W-1:0]  src;
        sx     = 16'(tx) + 16'(dx);
        sy     = 16'(ty) + 16'(dy);
        in_rng = !sx[15] && (sx < WB_C) && !sy[15] && (sy < WB_C);
        src    = CELL_W'(sy * WB_C + sx);
        saved[CELL_W'(ty * WINDOW_BLOCKS + tx)] = in_rng ? sync_map[src] : 1'b0;
      end
    end
  end

  // Pick the map the report is taken from
  always_comb begin
    if (cmd.full) begin
      sync_work = '0;
    end else if (recount) begin
      sync_work = saved;
    end else begin
      sync_work = sync_map;
    end
  end

  // Report the low sixteen cells
  for (genvar i = 0; i < 16; i++) begin : g_fresh
    if (i < CELLS) begin : g_cell
      assign fresh_bits[i] = ~sync_work[i];
    end else begin : g_none
      assign fresh_bits[i] = 1'b0;
    end
  end

  // Take a command when its result, if any, has a free slot
  assign has_result = cmd.moved || recount || cmd.focus;
  assign out_free   = !out_valid || !out_stall;
  assign pop        = q_stat.avail && (!has_result || out_free);

  // Window state
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_bx <= '0;
      origin_by <= '0;
      sync_map  <= '0;
    end else if (pop) begin
      if (recount) begin
        origin_bx <= cmd.blk_x;
        origin_by <= cmd.blk_y;
      end
      sync_map <= ALL_CELLS;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && has_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (pop && has_result) begin
      camera_moved   <= cmd.moved;
      camera_x       <= cmd.moved ? cmd.cam_x : '0;
      camera_y       <= cmd.moved ? cmd.cam_y : '0;
      window_shifted <= recount;
      origin_block_x <= recount ? cmd.blk_x : origin_bx;
      origin_block_y <= recount ? cmd.blk_y : origin_by;
      fresh_cells    <= fresh_bits;
      focus_changed  <= cmd.focus;
    end
  end

  `SBWT_ASSERT_NEXT(sync_full_after_pop, pop, sync_map == ALL_CELLS)
  `SBWT_ASSERT_NOW(cam_zero_when_still, out_valid && !camera_moved, camera_x == '0 && camera_y == '0)
  `SBWT_ASSERT_NEXT(shift_reported, pop && recount, out_valid && window_shifted)

endmodule

`default_nettype wire

>>> rtl/scrolling_block_window_tracker_unit.sv
// ----------------------------------------------------------------------------
// scrolling_block_window_tracker_unit
// Tracks the camera tile and the square window of map blocks around it.
//
// Input channel (in_valid / in_stall): operation with tile_x / tile_y.
// Move records a position, suspend forgets it, update recomputes the window
// and may give one result beat on the output channel (out_valid /
// out_stall) with flags, window origin and a mask of unsynced cells.
// Result path: an update's command is written into the queue when its beat
// is accepted, and the back end loads the output register when it pops that
// command. Throughput: one item per cycle while in_stall is low, set by the
// front classify stage and the back execute stage.
// Reset: camera suspended with no position, window origin at block zero,
// every cell unsynced, queue empty.
// Receiver stall: the result register holds, the back end stops, the
// two-entry command queue fills, and then in_stall rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scrolling_block_window_tracker_unit
  import sbwt_pkg::*;
#(
  parameter int BLOCK_TILES   = 8,
  parameter int VIEW_TILES    = 15,
  parameter int PAD_TILES     = 2,
  parameter int WINDOW_BLOCKS = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         operation,
  input  wire logic signed [15:0] tile_x,
  input  wire logic signed [15:0] tile_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    camera_moved,
  output logic signed [15:0]      camera_x,
  output logic signed [15:0]      camera_y,
  output logic                    window_shifted,
  output logic signed [13:0]      origin_block_x,
  output logic signed [13:0]      origin_block_y,
  output logic [15:0]             fresh_cells,
  output logic                    focus_changed
);

  queue_status_t q_stat;
  logic          push;
  logic          pop;
  cmd_t          wr_cmd;
  cmd_t          rd_cmd;

  // Front: accept and classify
  sbwt_front #(
    .BLOCK_TILES (BLOCK_TILES),
    .VIEW_TILES  (VIEW_TILES),
    .PAD_TILES   (PAD_TILES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .tile_x    (tile_x),
    .tile_y    (tile_y),
    .q_stat    (q_stat),
    .push      (push),
    .cmd       (wr_cmd)
  );

  // Command queue
  sbwt_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .stat   (q_stat)
  );

  // Back: execute and report
  sbwt_back #(
    .BLOCK_TILES   (BLOCK_TILES),
    .VIEW_TILES    (VIEW_TILES),
    .PAD_TILES     (PAD_TILES),
    .WINDOW_BLOCKS (WINDOW_BLOCKS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_stat         (q_stat),
    .cmd            (rd_cmd),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .camera_moved   (camera_moved),
    .camera_x       (camera_x),
    .camera_y       (camera_y),
    .window_shifted (window_shifted),
    .origin_block_x (origin_block_x),
    .origin_block_y (origin_block_y),
    .fresh_cells    (fresh_cells),
    .focus_changed  (focus_changed)
  );

endmodule

`default_nettype wire

>>> verif/window_tracker_checker.sv
// ----------------------------------------------------------------------------
// window_tracker_checker
// Watches both channels of the window tracker. It predicts each update's
// report beat from the accepted input beats and compares it with the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module window_tracker_checker
  import sbwt_pkg::*;
#(
  parameter int BLOCK_TILES   = 8,
  parameter int VIEW_TILES    = 15,
  parameter int PAD_TILES     = 2,
  parameter int WINDOW_BLOCKS = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [1:0]         operation,
  input  wire logic signed [15:0] tile_x,
  input  wire logic signed [15:0] tile_y,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic               camera_moved,
  input  wire logic signed [15:0] camera_x,
  input  wire logic signed [15:0] camera_y,
  input  wire logic               window_shifted,
  input  wire logic signed [13:0] origin_block_x,
  input  wire logic signed [13:0] origin_block_y,
  input  wire logic [15:0]        fresh_cells,
  input  wire logic               focus_changed,
  output int                      mismatches,
  output int                      pending_reports
);

  localparam int CELLS  = WINDOW_BLOCKS * WINDOW_BLOCKS;
  localparam int MARGIN = PAD_TILES + VIEW_TILES / 2;
  localparam int SPAN   = WINDOW_BLOCKS * BLOCK_TILES;
  localparam bit [63:0] ALL_CELLS = (CELLS >= 64) ? '1 : (64'd1 << CELLS) - 64'd1;

  typedef struct packed {
    logic               moved;
    logic signed [15:0] cam_x;
    logic signed [15:0] cam_y;
    logic               shifted;
    logic signed [13:0] org_x;
    logic signed [13:0] org_y;
    logic [15:0]        fresh;
    logic               focus;
  } report_t;

  // Camera and window state as the block should hold it
  logic signed [15:0] cam_x, cam_y;
  logic signed [13:0] org_x, org_y;
  bit                 has_pos, suspended;
  bit                 pend_unsusp, pend_move, pend_focus, pend_shift;
  bit [63:0]          synced;

  report_t expected_reports[$];
  report_t got, want;

  // Block index of the window's first cell for a camera tile
  function automatic logic signed [13:0] window_block(int pos);
    int t, q;
    t = pos - VIEW_TILES / 2 - PAD_TILES;
    q = t / BLOCK_TILES + ((t < 0) ? -1 : 0);
    return q[13:0];
  endfunction

  function automatic string show_report(report_t r);
    return $sformatf("moved=%0b cam=(%0d,%0d) shifted=%0b origin=(%0d,%0d) fresh=%04h focus=%0b",
                     r.moved, r.cam_x, r.cam_y, r.shifted, r.org_x, r.org_y, r.fresh,
                     r.focus);
  endfunction

  // Center the window on the camera and drop every synced cell
  task automatic recenter_window();
    org_x = window_block(cam_x);
    org_y = window_block(cam_y);
    pend_shift = 1'b1;
    synced = '0;
  endtask

  // Advance the predicted state by one input beat, queue any report
  task automatic track_item(input logic [1:0] op, input logic signed [15:0] tx,
                            input logic signed [15:0] ty);
    int cx, cy, fx, fy, dx, dy, sx, sy, col, row;
    bit [63:0] kept;
    bit moved;
    report_t rep;
    case (op)
      OP_MOVE: begin
        if (!(has_pos && tx == cam_x && ty == cam_y)) begin
          if (suspended && !pend_unsusp) begin
            suspended = 1'b0;
            pend_unsusp = 1'b1;
            pend_focus = 1'b1;
          end else begin
            pend_move = 1'b1;
          end
          cam_x = tx;
          cam_y = ty;
          has_pos = 1'b1;
        end
      end
      OP_SUSPEND: begin
        has_pos = 1'b0;
        suspended = 1'b1;
      end
      OP_UPDATE: begin
        moved = 1'b0;
        if ((pend_unsusp || pend_move) && has_pos) begin
          moved = 1'b1;
          if (pend_unsusp) begin
            recenter_window();
          end else if (!suspended) begin
            // Shift only when the camera gets within the margin of an edge
            cx = cam_x;
            cy = cam_y;
            fx = org_x * BLOCK_TILES;
            fy = org_y * BLOCK_TILES;
            if (cx - fx < MARGIN || cy - fy < MARGIN ||
                fx + SPAN - cx < MARGIN || fy + SPAN - cy < MARGIN) begin
              dx = window_block(cx) - org_x;
              dy = window_block(cy) - org_y;
              kept = '0;
              for (row = 0; row < WINDOW_BLOCKS; row++) begin
                for (col = 0; col < WINDOW_BLOCKS; col++) begin
                  sx = col - dx;
                  sy = row - dy;
                  if (sx >= 0 && sx < WINDOW_BLOCKS && sy >= 0 && sy < WINDOW_BLOCKS &&
                      synced[row * WINDOW_BLOCKS + col])
                    kept[sy * WINDOW_BLOCKS + sx] = 1'b1;
                end
              end
              recenter_window();
              synced = kept;
            end
          end
        end
        pend_unsusp = 1'b0;
        pend_move = 1'b0;

        rep.fresh = 16'(~synced & ALL_CELLS);
        synced = ALL_CELLS;
        rep.shifted = pend_shift;
        pend_shift = 1'b0;
        rep.focus = pend_focus;
        pend_focus = 1'b0;
        rep.moved = moved;
        rep.cam_x = moved ? cam_x : '0;
        rep.cam_y = moved ? cam_y : '0;
        rep.org_x = org_x;
        rep.org_y = org_y;
        if (moved || rep.shifted || rep.focus)
          expected_reports.insert(expected_reports.size(), rep);
      end
      default: ;
    endcase
  endtask

  initial mismatches = 0;

  // Compare output beats first, then fold in the accepted input beat
  always @(posedge clk) begin
    if (rst) begin
      cam_x = '0;
      cam_y = '0;
      org_x = '0;
      org_y = '0;
      has_pos = 1'b0;
      suspended = 1'b1;
      pend_unsusp = 1'b0;
      pend_move = 1'b0;
      pend_focus = 1'b0;
      pend_shift = 1'b0;
      synced = '0;
      expected_reports.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{camera_moved, camera_x, camera_y, window_shifted, origin_block_x,
                origin_block_y, fresh_cells, focus_changed};
        if (expected_reports.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected report beat: %s", show_report(got));
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("report mismatch\n  expected %s\n  actual   %s",
                       show_report(want), show_report(got));
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall)
        track_item(operation, tile_x, tile_y);
    end
    pending_reports <= expected_reports.size();
  end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the window tracker with a directed sequence of camera moves,
// suspends and updates, then a random camera walk, with random gaps on the
// input side and random stalls on the output side. The checker predicts and
// compares the report beats; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import sbwt_pkg::*;

  localparam int BLOCK_TILES    = 8;
  localparam int VIEW_TILES     = 15;
  localparam int PAD_TILES      = 2;
  localparam int WINDOW_BLOCKS  = 4;
  localparam int RANDOM_ITEMS   = 500;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               out_stall = 1'b0;
  logic [1:0]         operation = OP_MOVE;
  logic signed [15:0] tile_x = '0;
  logic signed [15:0] tile_y = '0;
  logic               in_stall, out_valid;
  logic               camera_moved, window_shifted, focus_changed;
  logic signed [15:0] camera_x, camera_y;
  logic signed [13:0] origin_block_x, origin_block_y;
  logic [15:0]        fresh_cells;

  int mismatches, pending_reports, quiet_cycles;
  bit gappy = 1'b1;
  bit draining = 1'b0;
  logic signed [15:0] walk_x, walk_y;

  scrolling_block_window_tracker_unit #(
    .BLOCK_TILES(BLOCK_TILES), .VIEW_TILES(VIEW_TILES),
    .PAD_TILES(PAD_TILES), .WINDOW_BLOCKS(WINDOW_BLOCKS)
  ) dut (.*);

  window_tracker_checker #(
    .BLOCK_TILES(BLOCK_TILES), .VIEW_TILES(VIEW_TILES),
    .PAD_TILES(PAD_TILES), .WINDOW_BLOCKS(WINDOW_BLOCKS)
  ) checker_i (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Present one input beat and hold it until accepted
  task automatic send_item(input logic [1:0] op, input logic signed [15:0] x,
                           input logic signed [15:0] y);
    int n;
    n = gappy ? idle_len() : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    tile_x <= x;
    tile_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Receiver stalls; released for good once the run drains
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (draining) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        n = ($urandom_range(0, 99) < 8) ? $urandom_range(40, 150) : 1 + idle_len();
        repeat (n) @(posedge clk);
        out_stall <= 1'b1;
        repeat (1 + idle_len()) @(posedge clk);
      end
    end
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int r, step_x, step_y;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset state, unsuspend, repeats, margins, extremes, suspends
    send_item(OP_UPDATE, 16'($urandom), 16'($urandom));
    send_item(OP_MOVE, 16'sd0, 16'sd0);
    send_item(OP_MOVE, 16'sd0, 16'sd0);
    send_item(OP_UPDATE, 16'($urandom), 16'($urandom));
    send_item(OP_UPDATE, 16'($urandom), 16'($urandom));
    send_item(OP_MOVE, 16'sd1, 16'sd0);
    send_item(OP_UPDATE, 16'($urandom), 16'($urandom));
    send_item(OP_MOVE, 16'sd20, -16'sd3);
    send_item(OP_UPDATE, 16'($urandom), 16'($urandom));
    send_item(OP_MOVE, 16'sh7fff, 16'sh7fff);
    send_item(OP_UPDATE, 16'($urandom), 16'($urandom));
    send_item(OP_MOVE, -16'sh8000, -16'sh8000);
    send_item(OP_UPDATE, 16'($urandom), 16'($urandom));
    send_item(OP_UNUSED, 16'($urandom), 16'($urandom));
    send_item(OP_SUSPEND, 16'($urandom), 16'($urandom));
    send_item(OP_UPDATE, 16'($urandom), 16'($urandom));
    // update with no position: only the focus flag survives
    send_item(OP_MOVE, 16'sd100, 16'sd100);
    send_item(OP_SUSPEND, 16'($urandom), 16'($urandom));
    send_item(OP_UPDATE, 16'($urandom), 16'($urandom));
    // move while suspended with the unsuspend still pending
    send_item(OP_MOVE, 16'sd5, 16'sd5);
    send_item(OP_SUSPEND, 16'($urandom), 16'($urandom));
    send_item(OP_MOVE, 16'sd6, 16'sd7);
    send_item(OP_UPDATE, 16'($urandom), 16'($urandom));
    send_item(OP_MOVE, 16'sd8, 16'sd7);
    send_item(OP_UPDATE, 16'($urandom), 16'($urandom));

    // Random camera walk, in bursts with and without input gaps
    walk_x = 16'sd8;
    walk_y = 16'sd7;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 25 == 0)
        gappy = ($urandom_range(0, 2) != 0);
      r = $urandom_range(0, 99);
      if (r < 48) begin
        step_x = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80) - 40
                                               : $urandom_range(0, 24) - 12;
        step_y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80) - 40
                                               : $urandom_range(0, 24) - 12;
        walk_x = 16'(walk_x + step_x);
        walk_y = 16'(walk_y + step_y);
        send_item(OP_MOVE, walk_x, walk_y);
      end else if (r < 80) begin
        send_item(OP_UPDATE, 16'($urandom), 16'($urandom));
      end else if (r < 85) begin
        send_item(OP_SUSPEND, 16'($urandom), 16'($urandom));
      end else if (r < 88) begin
        send_item(OP_UNUSED, 16'($urandom), 16'($urandom));
      end else if (r < 93) begin
        walk_x = 16'($urandom);
        walk_y = 16'($urandom);
        send_item(OP_MOVE, walk_x, walk_y);
      end else if (r < 97) begin
        send_item(OP_MOVE, walk_x, walk_y);
      end else begin
        walk_x = 16'(($urandom_range(0, 1) ? 16'sh7fff : -16'sh8000) +
                     $urandom_range(0, 6) - 3);
        walk_y = 16'(($urandom_range(0, 1) ? 16'sh7fff : -16'sh8000) +
                     $urandom_range(0, 6) - 3);
        send_item(OP_MOVE, walk_x, walk_y);
      end
    end
    send_item(OP_UPDATE, 16'($urandom), 16'($urandom));

    // Drain the pipeline, then watch for stray beats
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports != 0) @(posedge clk);
    draining = 1'b1;
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
